// ----- rtl/bale_pkg.sv -----
// ----------------------------------------------------------------------------
// bale_pkg
// Shared widths, operation and status codes, and the command/status bundles
// passed between the list controller and the list datapath.
// ----------------------------------------------------------------------------
package bale_pkg;

   localparam int KindW   = 3;
   localparam int ValueW  = 32;
   localparam int PosW    = 10;
   localparam int StatusW = 2;
   localparam int IndexW  = 10;
   localparam int CountW  = 11;

   typedef enum logic [KindW-1:0] {
      KIND_APPEND  = 3'd0,
      KIND_DEL_POS = 3'd1,
      KIND_DEL_VAL = 3'd2,
      KIND_FIND    = 3'd3,
      KIND_READ    = 3'd4,
      KIND_CLEAR   = 3'd5
   } kind_type;

   typedef enum logic [StatusW-1:0] {
      STATUS_OK     = 2'd0,
      STATUS_FULL   = 2'd1,
      STATUS_RANGE  = 2'd2,
      STATUS_ABSENT = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      IDX_HOLD,
      IDX_ZERO,
      IDX_INC
   } idx_op_type;

   typedef enum logic [1:0] {
      CNT_HOLD,
      CNT_INC,
      CNT_DEC,
      CNT_ZERO
   } cnt_op_type;

   typedef struct packed {
      logic       load_req;   // capture the accepted request
      idx_op_type idx_op;
      cnt_op_type cnt_op;
      logic       mem_we;
      logic       wr_shift;   // 1: move read data down to idx, 0: append at count
      logic       rd_next;    // read address idx + 1 instead of idx
      logic       status_we;
      status_type status;
      logic       rsp_load;
   } ctrl_cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     full;
      logic     pos_ok;
      logic     cnt_zero;
      logic     match;
      logic     last;         // idx + 1 has reached count
      logic     out_free;
   } dp_stat_type;

endpackage

// ----- rtl/bale_if.sv -----
// ----------------------------------------------------------------------------
// bale_req_if / bale_rsp_if
// Valid/ready channels for list requests and list responses.
// ----------------------------------------------------------------------------
interface bale_req_if;
   logic                               valid;
   logic                               ready;
   logic        [bale_pkg::KindW-1:0]  kind;
   logic signed [bale_pkg::ValueW-1:0] item_value;
   logic        [bale_pkg::PosW-1:0]   position;

   modport source (output valid, output kind, output item_value, output position,
                   input ready);
   modport sink   (input valid, input kind, input item_value, input position,
                   output ready);
endinterface

interface bale_rsp_if;
   logic                                valid;
   logic                                ready;
   logic        [bale_pkg::StatusW-1:0] status;
   logic        [bale_pkg::IndexW-1:0]  found_index;
   logic signed [bale_pkg::ValueW-1:0]  read_value;
   logic        [bale_pkg::CountW-1:0]  element_count;

   modport source (output valid, output status, output found_index, output read_value,
                   output element_count, input ready);
   modport sink   (input valid, input status, input found_index, input read_value,
                   input element_count, output ready);
endinterface

// ----- rtl/bounded_array_list_engine_unit.sv -----
// ----------------------------------------------------------------------------
// bounded_array_list_engine_unit
// Packed list of signed 32-bit entries with append, delete, find, read, clear.
// Sequence: accept, decode, then reply for append, read, clear and unused kinds;
//   find and delete-by-value scan entries from index 0 (address, test) up to
//   the match; both deletes then move each later entry down (read, write) and
//   drop the count. Reply waits until the response register is free.
// One operation at a time; the one read port of the entry memory paces scan and shift.
// Reset: synchronous; count and response valid clear, entries keep old data.
// ----------------------------------------------------------------------------
module bounded_array_list_engine_unit #(
   parameter int DEPTH = 1024
) (
   input logic        clock,
   input logic        reset,
   bale_req_if.sink   req_chan,
   bale_rsp_if.source rsp_chan
);

   bale_pkg::ctrl_cmd_type cmd;
   bale_pkg::dp_stat_type  stat;

   bale_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   bale_datapath #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_kind          (req_chan.kind),
      .req_item_value    (req_chan.item_value),
      .req_position      (req_chan.position),
      .rsp_ready         (rsp_chan.ready),
      .rsp_valid         (rsp_chan.valid),
      .rsp_status        (rsp_chan.status),
      .rsp_found_index   (rsp_chan.found_index),
      .rsp_read_value    (rsp_chan.read_value),
      .rsp_element_count (rsp_chan.element_count)
   );

   // the block does not accept a request in the cycle after taking a transaction
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> !req_chan.ready)
      else $error("request accepted back to back");

   // a new response never overwrites one still waiting
   a_no_rsp_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> stat.out_free)
      else $error("response register overwritten");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.status == bale_pkg::STATUS_FULL |->
      rsp_chan.element_count == bale_pkg::CountW'(DEPTH))
      else $error("full status with count below capacity");

   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.found_index != '0 |->
      rsp_chan.status == bale_pkg::STATUS_OK)
      else $error("nonzero index on failed operation");

endmodule

// ----- rtl/bale_datapath.sv -----
// ----------------------------------------------------------------------------
// bale_datapath
// Entry memory, count, working index, compare logic and response register.
// ----------------------------------------------------------------------------
module bale_datapath #(
   parameter int DEPTH = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  bale_pkg::ctrl_cmd_type             cmd,
   output bale_pkg::dp_stat_type              stat,
   input  logic        [bale_pkg::KindW-1:0]  req_kind,
   input  logic signed [bale_pkg::ValueW-1:0] req_item_value,
   input  logic        [bale_pkg::PosW-1:0]   req_position,
   input  logic                               rsp_ready,
   output logic                               rsp_valid,
   output logic        [bale_pkg::StatusW-1:0] rsp_status,
   output logic        [bale_pkg::IndexW-1:0] rsp_found_index,
   output logic signed [bale_pkg::ValueW-1:0] rsp_read_value,
   output logic        [bale_pkg::CountW-1:0] rsp_element_count
);

   localparam int AW   = $clog2(DEPTH);
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CmpW = (CW > bale_pkg::PosW) ? CW : bale_pkg::PosW;

   logic signed [bale_pkg::ValueW-1:0] entries_ff [DEPTH];
   logic signed [bale_pkg::ValueW-1:0] rd_data_ff;

   logic        [bale_pkg::KindW-1:0]  kind_ff;
   logic signed [bale_pkg::ValueW-1:0] val_ff;
   logic        [bale_pkg::PosW-1:0]   pos_ff;
   logic        [CW-1:0]               count_ff, count_in;
   logic        [CW-1:0]               idx_ff, idx_in;
   logic        [CW-1:0]               idx_next;
   bale_pkg::status_type               status_ff;

   logic                               rsp_valid_ff;
   logic        [bale_pkg::StatusW-1:0] rsp_status_ff;
   logic        [bale_pkg::IndexW-1:0] rsp_found_ff;
   logic signed [bale_pkg::ValueW-1:0] rsp_read_ff;
   logic        [bale_pkg::CountW-1:0] rsp_count_ff;

   logic        [AW-1:0]               rd_addr, wr_addr;
   logic signed [bale_pkg::ValueW-1:0] wr_data;
   logic                               status_ok;

   assign idx_next  = idx_ff + CW'(1);
   assign rd_addr   = cmd.rd_next ? idx_next[AW-1:0] : idx_ff[AW-1:0];
   assign wr_addr   = cmd.wr_shift ? idx_ff[AW-1:0] : count_ff[AW-1:0];
   assign wr_data   = cmd.wr_shift ? rd_data_ff : val_ff;
   assign status_ok = (status_ff == bale_pkg::STATUS_OK);

   // entry memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.mem_we) begin
         entries_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= entries_ff[rd_addr];
   end

   always_comb begin
      case (cmd.cnt_op)
         bale_pkg::CNT_INC:  count_in = count_ff + CW'(1);
         bale_pkg::CNT_DEC:  count_in = count_ff - CW'(1);
         bale_pkg::CNT_ZERO: count_in = '0;
         default:            count_in = count_ff;
      endcase
   end

   always_comb begin
      if (cmd.load_req) begin
         idx_in = CW'(req_position);
      end else begin
         case (cmd.idx_op)
            bale_pkg::IDX_ZERO: idx_in = '0;
            bale_pkg::IDX_INC:  idx_in = idx_next;
            default:            idx_in = idx_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (cmd.load_req) begin
         kind_ff <= req_kind;
         val_ff  <= req_item_value;
         pos_ff  <= req_position;
      end
      if (cmd.status_we) begin
         status_ff <= cmd.status;
      end
      if (cmd.rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_found_ff  <= (kind_ff == bale_pkg::KIND_FIND && status_ok) ?
                          bale_pkg::IndexW'(idx_ff) : '0;
         rsp_read_ff   <= (kind_ff == bale_pkg::KIND_READ && status_ok) ? rd_data_ff : '0;
         rsp_count_ff  <= bale_pkg::CountW'(count_ff);
      end
   end

   assign stat.kind     = bale_pkg::kind_type'(kind_ff);
   assign stat.full     = (count_ff == CW'(DEPTH));
   assign stat.pos_ok   = (CmpW'(pos_ff) < CmpW'(count_ff));
   assign stat.cnt_zero = (count_ff == '0);
   assign stat.match    = (rd_data_ff == val_ff);
   assign stat.last     = (idx_next >= count_ff);
   assign stat.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_found_index   = rsp_found_ff;
   assign rsp_read_value    = rsp_read_ff;
   assign rsp_element_count = rsp_count_ff;

endmodule

// ----- rtl/bale_controller.sv -----
// ----------------------------------------------------------------------------
// bale_controller
// Sequencer for list operations: decode, linear scan, shift-down, response.
// ----------------------------------------------------------------------------
module bale_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  bale_pkg::dp_stat_type  stat,
   output bale_pkg::ctrl_cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN_ADDR,
      ST_SCAN_TEST,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_REPLY
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.idx_op     = bale_pkg::IDX_HOLD;
      cmd.cnt_op     = bale_pkg::CNT_HOLD;
      cmd.status     = bale_pkg::STATUS_OK;
      req_ready      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_DECODE;
            end
         end

         ST_DECODE: begin
            cmd.status_we = 1'b1;
            state_in      = ST_REPLY;
            unique case (stat.kind) inside
               bale_pkg::KIND_APPEND: begin
                  if (stat.full) begin
                     cmd.status = bale_pkg::STATUS_FULL;
                  end else begin
                     cmd.mem_we = 1'b1;
                     cmd.cnt_op = bale_pkg::CNT_INC;
                  end
               end
               bale_pkg::KIND_DEL_POS: begin
                  if (!stat.pos_ok) begin
                     cmd.status = bale_pkg::STATUS_RANGE;
                  end else begin
                     state_in = ST_SHIFT_RD;
                  end
               end
               bale_pkg::KIND_DEL_VAL, bale_pkg::KIND_FIND: begin
                  cmd.idx_op = bale_pkg::IDX_ZERO;
                  if (stat.cnt_zero) begin
                     cmd.status = bale_pkg::STATUS_ABSENT;
                  end else begin
                     state_in = ST_SCAN_ADDR;
                  end
               end
               bale_pkg::KIND_READ: begin
                  // entry at position is being read this cycle
                  if (!stat.pos_ok) begin
                     cmd.status = bale_pkg::STATUS_RANGE;
                  end
               end
               bale_pkg::KIND_CLEAR: begin
                  cmd.cnt_op = bale_pkg::CNT_ZERO;
               end
               default: begin
               end
            endcase
         end

         ST_SCAN_ADDR: begin
            state_in = ST_SCAN_TEST;
         end

         ST_SCAN_TEST: begin
            if (stat.match) begin
               state_in = (stat.kind == bale_pkg::KIND_FIND) ? ST_REPLY : ST_SHIFT_RD;
            end else if (stat.last) begin
               cmd.status_we = 1'b1;
               cmd.status    = bale_pkg::STATUS_ABSENT;
               state_in      = ST_REPLY;
            end else begin
               cmd.idx_op = bale_pkg::IDX_INC;
               state_in   = ST_SCAN_ADDR;
            end
         end

         ST_SHIFT_RD: begin
            if (stat.last) begin
               cmd.cnt_op = bale_pkg::CNT_DEC;
               state_in   = ST_REPLY;
            end else begin
               cmd.rd_next = 1'b1;
               state_in    = ST_SHIFT_WR;
            end
         end

         ST_SHIFT_WR: begin
            cmd.mem_we   = 1'b1;
            cmd.wr_shift = 1'b1;
            cmd.idx_op   = bale_pkg::IDX_INC;
            state_in     = ST_SHIFT_RD;
         end

         ST_REPLY: begin
            if (stat.out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- sim/tb_bounded_array_list_engine_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bounded_array_list_engine_unit
// Drives list operations into the engine through a queue-fed driver and checks
// every response against an in-bench model of the packed list. Directed
// corner cases come first, then random traffic on short lists, with one pass
// that fills the list to capacity while the response side is held off.
// ----------------------------------------------------------------------------
module tb_bounded_array_list_engine_unit;

   localparam int LIST_DEPTH   = 1024;
   localparam int LIST_AW      = $clog2(LIST_DEPTH);
   localparam int RANDOM_OPS   = 640;
   localparam int FILL_AT      = 250;
   localparam int CALM_AT      = 560;
   localparam int LONG_HOLD    = 300;
   localparam int DRAIN_CYCLES = 50;
   localparam int CYCLE_LIMIT  = 2_000_000;

   // kinds with no operation behind them
   localparam logic [bale_pkg::KindW-1:0] KIND_UNUSED_LO = 3'd6;
   localparam logic [bale_pkg::KindW-1:0] KIND_UNUSED_HI = 3'd7;

   typedef struct {
      logic        [bale_pkg::KindW-1:0]  kind;
      logic signed [bale_pkg::ValueW-1:0] item_value;
      logic        [bale_pkg::PosW-1:0]   position;
   } list_op_type;

   typedef struct {
      bale_pkg::status_type                status;
      logic        [bale_pkg::IndexW-1:0]  found_index;
      logic signed [bale_pkg::ValueW-1:0]  read_value;
      logic        [bale_pkg::CountW-1:0]  element_count;
   } list_rsp_type;

   logic clock;
   logic reset;

   bale_req_if req_if ();
   bale_rsp_if rsp_if ();

   bounded_array_list_engine_unit #(
      .DEPTH (LIST_DEPTH)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // list model state
   logic signed [bale_pkg::ValueW-1:0] list_mem [LIST_DEPTH];
   int unsigned                        list_count;

   list_op_type  pend_q [$];
   list_rsp_type rsp_expect_q [$];
   list_op_type  cur_op;

   int unsigned mismatch_count;
   int unsigned cycle_count;
   int unsigned gap_left;
   int unsigned stall_left;
   int unsigned hold_left;
   int          hold_ask;
   int          hold_seen;
   bit          calm;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---------------- list model ----------------
   function automatic int unsigned first_hit(logic signed [bale_pkg::ValueW-1:0] v);
      for (int unsigned i = 0; i < list_count; i++) begin
         if (list_mem[LIST_AW'(i)] == v) return i;
      end
      return list_count;
   endfunction

   function automatic void drop_entry(int unsigned idx);
      for (int unsigned i = idx; i + 1 < list_count; i++) begin
         list_mem[LIST_AW'(i)] = list_mem[LIST_AW'(i + 1)];
      end
      list_count--;
   endfunction

   function automatic list_rsp_type apply_list_op(list_op_type op);
      list_rsp_type r;
      int unsigned  hit;
      r.status      = bale_pkg::STATUS_OK;
      r.found_index = '0;
      r.read_value  = '0;
      case (op.kind)
         bale_pkg::KIND_APPEND: begin
            if (list_count >= LIST_DEPTH) begin
               r.status = bale_pkg::STATUS_FULL;
            end else begin
               list_mem[LIST_AW'(list_count)] = op.item_value;
               list_count++;
            end
         end
         bale_pkg::KIND_DEL_POS: begin
            if (32'(op.position) >= list_count) r.status = bale_pkg::STATUS_RANGE;
            else drop_entry(32'(op.position));
         end
         bale_pkg::KIND_DEL_VAL: begin
            hit = first_hit(op.item_value);
            if (hit >= list_count) r.status = bale_pkg::STATUS_ABSENT;
            else drop_entry(hit);
         end
         bale_pkg::KIND_FIND: begin
            hit = first_hit(op.item_value);
            if (hit >= list_count) r.status = bale_pkg::STATUS_ABSENT;
            else r.found_index = hit[bale_pkg::IndexW-1:0];
         end
         bale_pkg::KIND_READ: begin
            if (32'(op.position) >= list_count) r.status = bale_pkg::STATUS_RANGE;
            else r.read_value = list_mem[op.position];
         end
         bale_pkg::KIND_CLEAR: list_count = 0;
         default: ;
      endcase
      r.element_count = list_count[bale_pkg::CountW-1:0];
      return r;
   endfunction

   function automatic void report_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("mismatch: %s", msg);
   endfunction

   // ---------------- request driver ----------------
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid      <= 1'b0;
         req_if.kind       <= '0;
         req_if.item_value <= '0;
         req_if.position   <= '0;
         gap_left = 0;
      end else begin
         if (req_if.valid === 1'b1 && req_if.ready === 1'b1) begin
            rsp_expect_q.push_back(apply_list_op(cur_op));
         end
         if (req_if.valid !== 1'b1 || req_if.ready === 1'b1) begin
            if (gap_left != 0) begin
               req_if.valid <= 1'b0;
               gap_left--;
            end else if (pend_q.size() != 0 && !calm && $urandom_range(0, 5) == 0) begin
               req_if.valid <= 1'b0;
               gap_left = $urandom_range(1, 5) - 1;
            end else if (pend_q.size() != 0) begin
               cur_op = pend_q.pop_front();
               req_if.valid      <= 1'b1;
               req_if.kind       <= cur_op.kind;
               req_if.item_value <= cur_op.item_value;
               req_if.position   <= cur_op.position;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------- response ready, bursts and long hold-off ----------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left = 0;
         hold_left  = 0;
         hold_seen  = 0;
      end else if (hold_ask != hold_seen) begin
         hold_seen = hold_ask;
         hold_left = LONG_HOLD;
         rsp_if.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left--;
         rsp_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 5) - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // ---------------- response monitor ----------------
   always @(posedge clock) begin
      list_rsp_type exp_rsp;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (rsp_expect_q.size() == 0) begin
            report_mismatch("response with no request outstanding");
         end else begin
            exp_rsp = rsp_expect_q.pop_front();
            if (rsp_if.status !== exp_rsp.status
                || rsp_if.found_index !== exp_rsp.found_index
                || rsp_if.read_value !== exp_rsp.read_value
                || rsp_if.element_count !== exp_rsp.element_count) begin
               report_mismatch($sformatf(
                  "exp st=%0d idx=%0d rd=%0d cnt=%0d  got st=%0d idx=%0d rd=%0d cnt=%0d",
                  exp_rsp.status, exp_rsp.found_index, exp_rsp.read_value,
                  exp_rsp.element_count, rsp_if.status, rsp_if.found_index,
                  rsp_if.read_value, rsp_if.element_count));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[bounded_array_list_engine_unit] ERROR");
         $finish;
      end
   end

   // ---------------- stimulus helpers ----------------
   task automatic push_op(input logic [bale_pkg::KindW-1:0] k,
                          input logic signed [bale_pkg::ValueW-1:0] v,
                          input logic [bale_pkg::PosW-1:0] p);
      list_op_type op;
      @(negedge clock);
      while (pend_q.size() >= 4) @(negedge clock);
      op.kind       = k;
      op.item_value = v;
      op.position   = p;
      pend_q.push_back(op);
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (pend_q.size() != 0 || req_if.valid === 1'b1 || rsp_expect_q.size() != 0);
   endtask

   // small values repeat often so first-match and duplicate handling get exercised
   function automatic logic signed [bale_pkg::ValueW-1:0] pick_value();
      int unsigned sel;
      sel = $urandom_range(0, 9);
      case (sel) inside
         0:       return 32'sh8000_0000;
         1:       return 32'sh7fff_ffff;
         [2:4]:   return $signed($urandom_range(0, 15)) - 8;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [bale_pkg::PosW-1:0] pick_position(int unsigned cnt);
      int unsigned sel;
      sel = $urandom_range(0, 9);
      if (cnt != 0 && sel < 8) return bale_pkg::PosW'($urandom_range(0, cnt - 1));
      if (sel == 8) return cnt[bale_pkg::PosW-1:0];
      return bale_pkg::PosW'($urandom_range(0, LIST_DEPTH - 1));
   endfunction

   // fill to capacity under a long response hold-off, then work the full list
   task automatic run_full_list();
      logic signed [bale_pkg::ValueW-1:0] tail_val;
      logic signed [bale_pkg::ValueW-1:0] mid_val;
      wait_idle();
      hold_ask++;
      push_op(bale_pkg::KIND_CLEAR, '0, '0);
      for (int unsigned i = 0; i < LIST_DEPTH + 2; i++) begin
         push_op(bale_pkg::KIND_APPEND, pick_value(), bale_pkg::PosW'($urandom()));
      end
      wait_idle();
      tail_val = list_mem[LIST_AW'(LIST_DEPTH - 1)];
      mid_val  = list_mem[LIST_AW'(900)];
      push_op(bale_pkg::KIND_READ, '0, 10'd1023);
      push_op(bale_pkg::KIND_FIND, tail_val, '0);
      push_op(bale_pkg::KIND_FIND, $urandom(), '0);
      push_op(bale_pkg::KIND_DEL_VAL, $urandom(), '0);
      push_op(bale_pkg::KIND_DEL_POS, '0, 10'd1023);
      push_op(bale_pkg::KIND_APPEND, 32'sh5a5a_a5a5, '0);
      push_op(bale_pkg::KIND_APPEND, 32'sh0000_0001, '0);
      push_op(bale_pkg::KIND_DEL_VAL, mid_val, '0);
      push_op(bale_pkg::KIND_DEL_POS, '0, 10'd0);
      push_op(bale_pkg::KIND_READ, '0, 10'd1022);
      push_op(bale_pkg::KIND_CLEAR, '0, '0);
   endtask

   // ---------------- main sequence ----------------
   initial begin
      int unsigned cap;
      int unsigned cnt;
      int unsigned r;
      logic [bale_pkg::KindW-1:0] k;
      logic signed [bale_pkg::ValueW-1:0] v;

      reset             = 1'b1;
      calm              = 1'b0;
      hold_ask          = 0;
      mismatch_count    = 0;
      cycle_count       = 0;
      list_count        = 0;
      req_if.valid      = 1'b0;
      req_if.kind       = '0;
      req_if.item_value = '0;
      req_if.position   = '0;
      rsp_if.ready      = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed corners: empty list, extremes, first match, last/first delete
      push_op(bale_pkg::KIND_CLEAR, '0, '0);
      push_op(bale_pkg::KIND_READ, '0, 10'd0);
      push_op(bale_pkg::KIND_DEL_POS, '0, 10'd0);
      push_op(bale_pkg::KIND_DEL_VAL, 32'sd5, '0);
      push_op(bale_pkg::KIND_FIND, 32'sd0, '0);
      push_op(bale_pkg::KIND_APPEND, 32'sh8000_0000, 10'd1023);
      push_op(bale_pkg::KIND_APPEND, 32'sh7fff_ffff, '0);
      push_op(bale_pkg::KIND_APPEND, 32'sd0, '0);
      push_op(bale_pkg::KIND_APPEND, -32'sd1, '0);
      push_op(bale_pkg::KIND_APPEND, 32'sh7fff_ffff, '0);
      push_op(bale_pkg::KIND_FIND, 32'sh7fff_ffff, '0);
      push_op(bale_pkg::KIND_FIND, -32'sd1, '0);
      push_op(bale_pkg::KIND_READ, '0, 10'd0);
      push_op(bale_pkg::KIND_READ, '0, 10'd5);
      push_op(bale_pkg::KIND_READ, '0, 10'd1023);
      push_op(bale_pkg::KIND_DEL_VAL, 32'sh7fff_ffff, '0);
      push_op(bale_pkg::KIND_READ, '0, 10'd3);
      push_op(bale_pkg::KIND_DEL_POS, '0, 10'd3);
      push_op(bale_pkg::KIND_DEL_POS, '0, 10'd0);
      push_op(KIND_UNUSED_LO, -32'sd1, 10'd1023);
      push_op(KIND_UNUSED_HI, 32'sh8000_0000, 10'd512);
      push_op(bale_pkg::KIND_FIND, 32'sh8000_0000, '0);
      push_op(bale_pkg::KIND_CLEAR, '0, '0);
      push_op(bale_pkg::KIND_READ, '0, 10'd0);

      cap = 8;
      for (int unsigned n = 0; n < RANDOM_OPS; n++) begin
         if (n == FILL_AT) run_full_list();
         if (n == CALM_AT) calm = 1'b1;
         if (n % 100 == 0) cap = $urandom_range(2, 28);
         cnt = list_count;
         r = $urandom_range(0, 99);
         if (r < ((cnt < cap) ? 45 : 12)) begin
            k = bale_pkg::KIND_APPEND;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 22)      k = bale_pkg::KIND_FIND;
            else if (r < 44) k = bale_pkg::KIND_READ;
            else if (r < 64) k = bale_pkg::KIND_DEL_VAL;
            else if (r < 84) k = bale_pkg::KIND_DEL_POS;
            else if (r < 90) k = bale_pkg::KIND_CLEAR;
            else if (r < 95) k = bale_pkg::KindW'($urandom_range(KIND_UNUSED_LO,
                                                                 KIND_UNUSED_HI));
            else             k = bale_pkg::KIND_APPEND;
         end
         // searches mostly hit a value that is in the list
         if ((k == bale_pkg::KIND_FIND || k == bale_pkg::KIND_DEL_VAL) && cnt != 0
             && $urandom_range(0, 3) != 0)
            v = list_mem[LIST_AW'($urandom_range(0, cnt - 1))];
         else
            v = pick_value();
         push_op(k, v, pick_position(cnt));
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && rsp_expect_q.size() == 0) begin
         $display("[bounded_array_list_engine_unit] OK");
      end else begin
         $display("[bounded_array_list_engine_unit] ERROR");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/bale_pkg.sv
rtl/bale_if.sv
rtl/bale_datapath.sv
rtl/bale_controller.sv
rtl/bounded_array_list_engine_unit.sv
sim/tb_bounded_array_list_engine_unit.sv
